// ===== rtl/core/ir_remote_frame_encoder_assert.svh =====
// Assertion macros used by the encoder top level.
`ifndef IR_REMOTE_FRAME_ENCODER_ASSERT_SVH
`define IR_REMOTE_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IRFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IRFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/irfe_pkg.sv =====
package irfe_pkg;

  // Protocol codes on the operation field
  typedef enum logic [2:0] {
    PROTO_NEC  = 3'd0,
    PROTO_NECX = 3'd1,
    PROTO_RC5  = 3'd2,
    PROTO_SAM  = 3'd3,
    PROTO_SIRC = 3'd4,
    PROTO_RC6  = 3'd5,
    PROTO_KASE = 3'd6,
    PROTO_NONE = 3'd7
  } proto_t;

  // Carrier codes
  localparam logic [1:0] CAR_36 = 2'd0;
  localparam logic [1:0] CAR_38 = 2'd1;
  localparam logic [1:0] CAR_40 = 2'd2;

  localparam int TimeW   = 10;
  localparam int StreamW = 48;
  localparam int CntW    = 6;

  // Element durations, 10 us units
  localparam logic [TimeW-1:0] T_NEC_HM  = 10'd900;
  localparam logic [TimeW-1:0] T_NEC_HS  = 10'd450;
  localparam logic [TimeW-1:0] T_NEC_M   = 10'd56;
  localparam logic [TimeW-1:0] T_NEC_S1  = 10'd168;
  localparam logic [TimeW-1:0] T_RC5_H   = 10'd89;
  localparam logic [TimeW-1:0] T_SAM_H   = 10'd450;
  localparam logic [TimeW-1:0] T_SAM_M   = 10'd55;
  localparam logic [TimeW-1:0] T_SAM_S1  = 10'd165;
  localparam logic [TimeW-1:0] T_SIRC_HM = 10'd240;
  localparam logic [TimeW-1:0] T_SIRC_U  = 10'd60;
  localparam logic [TimeW-1:0] T_SIRC_M1 = 10'd120;
  localparam logic [TimeW-1:0] T_SIRC_GP = 10'd1000;
  localparam logic [TimeW-1:0] T_RC6_HM  = 10'd266;
  localparam logic [TimeW-1:0] T_RC6_HS  = 10'd89;
  localparam logic [TimeW-1:0] T_RC6_H   = 10'd44;
  localparam logic [TimeW-1:0] T_RC6_GP  = 10'd266;
  localparam logic [TimeW-1:0] T_KASE_HM = 10'd338;
  localparam logic [TimeW-1:0] T_KASE_HS = 10'd169;
  localparam logic [TimeW-1:0] T_KASE_M  = 10'd42;
  localparam logic [TimeW-1:0] T_KASE_S1 = 10'd126;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_BITS,
    ST_TAIL
  } state_t;

  // Which element of the frame is produced
  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_BIT,
    SEL_TAIL
  } elem_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    logic      advance;
    logic      last;
    elem_sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_valid;
    logic has_header;
    logic has_trailer;
    logic bit_done;
    logic cnt_one;
  } dp_status_t;

  // Reverse eight bits so an MSB-first field goes out first from bit 0
  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ir_remote_frame_encoder.sv =====
// The item's edge loads the frame; the header state then registers the first element,
// or for RC-5, which has no header and spends its header state idle, the first bit state.
// One element per cycle while a frame goes out; busy covers an N-element frame (9 to 50),
// also the idle header state for RC-5, and only the header state for the unused protocol
// code. The next item is taken once busy is low. Results cannot be stalled.
// Reset (rst, synchronous, active high) returns the sequencer to idle and clears strobe.
`include "ir_remote_frame_encoder_assert.svh"

module ir_remote_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [25:0] address,
  input  logic [15:0] command,
  input  logic [4:0]  addr_width,
  output logic [9:0]  mark_time,
  output logic [9:0]  space_time,
  output logic [1:0]  carrier_select,
  output logic        last,
  output logic        strobe
);

  irfe_pkg::ctrl_cmd_t  cmd;
  irfe_pkg::dp_status_t sts;

  irfe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  irfe_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (operation),
    .address        (address),
    .command        (command),
    .addr_width     (addr_width),
    .sts            (sts),
    .mark_time      (mark_time),
    .space_time     (space_time),
    .carrier_select (carrier_select),
    .last           (last),
    .strobe         (strobe)
  );

  // Check sequencing between control and outputs
  `IRFE_ASSERT_NEXT(a_take_sets_busy, clk, rst, start && !busy, busy, "item taken but not busy")
  `IRFE_ASSERT_NOW(a_strobe_in_frame, clk, rst, strobe, $past(busy), "element outside a frame")
  `IRFE_ASSERT_NOW(a_last_ends_frame, clk, rst, strobe && last, !busy, "busy after last element")

endmodule

// ===== rtl/core/irfe_ctrl.sv =====
module irfe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  irfe_pkg::dp_status_t  sts,
  output irfe_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  irfe_pkg::state_t state;
  irfe_pkg::state_t state_next;
  logic             final_bit;

  assign final_bit = sts.bit_done && sts.cnt_one;
  assign busy      = (state != irfe_pkg::ST_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      irfe_pkg::ST_IDLE: begin
        if (start) state_next = irfe_pkg::ST_HEAD;
      end
      irfe_pkg::ST_HEAD: begin
        state_next = sts.op_valid ? irfe_pkg::ST_BITS : irfe_pkg::ST_IDLE;
      end
      irfe_pkg::ST_BITS: begin
        if (final_bit) begin
          state_next = sts.has_trailer ? irfe_pkg::ST_TAIL : irfe_pkg::ST_IDLE;
        end
      end
      irfe_pkg::ST_TAIL: begin
        state_next = irfe_pkg::ST_IDLE;
      end
      default: state_next = irfe_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '{load: 1'b0, emit: 1'b0, advance: 1'b0, last: 1'b0,
            sel: irfe_pkg::SEL_BIT};
    case (state)
      irfe_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      irfe_pkg::ST_HEAD: begin
        cmd.sel  = irfe_pkg::SEL_HEAD;
        cmd.emit = sts.op_valid && sts.has_header;
      end
      irfe_pkg::ST_BITS: begin
        cmd.emit    = 1'b1;
        cmd.advance = 1'b1;
        cmd.last    = final_bit && !sts.has_trailer;
      end
      irfe_pkg::ST_TAIL: begin
        cmd.sel  = irfe_pkg::SEL_TAIL;
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/irfe_datapath.sv =====
module irfe_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  irfe_pkg::ctrl_cmd_t  cmd,
  input  logic [2:0]           operation,
  input  logic [25:0]          address,
  input  logic [15:0]          command,
  input  logic [4:0]           addr_width,
  output irfe_pkg::dp_status_t sts,
  output logic [9:0]           mark_time,
  output logic [9:0]           space_time,
  output logic [1:0]           carrier_select,
  output logic                 last,
  output logic                 strobe
);

  logic [2:0]                    op;
  logic [irfe_pkg::StreamW-1:0]  stream;
  logic [irfe_pkg::CntW-1:0]     cnt;
  logic                          half;

  logic [irfe_pkg::StreamW-1:0]  stream_next;
  logic [irfe_pkg::CntW-1:0]     cnt_next;
  logic [4:0]                    abits_sat;
  logic [7:0]                    kb0, kb1, kb2, kb3, kb4, kb5;
  logic [7:0]                    kpar;
  logic                          biphase;
  logic                          b;
  logic [9:0]                    mk, sp;
  logic [1:0]                    car;

  assign abits_sat = (addr_width > 5'd16) ? 5'd16 : addr_width;

  // Kaseikyo bytes with nibble and byte parity
  assign kb0  = address[15:8];
  assign kb1  = address[23:16];
  assign kpar = kb0 ^ kb1;
  assign kb2  = {address[7:4], kpar[3:0] ^ kpar[7:4]};
  assign kb3  = {command[3:0], address[3:0]};
  assign kb4  = {address[25:24], command[9:4]};
  assign kb5  = kb2 ^ kb3 ^ kb4;

  // Build the bit stream in send order, bit 0 first
  always_comb begin
    stream_next = '0;
    cnt_next    = '0;
    case (irfe_pkg::proto_t'(operation))
      irfe_pkg::PROTO_NEC: begin
        stream_next = {16'd0, ~command[7:0], command[7:0], ~address[7:0], address[7:0]};
        cnt_next    = 6'd32;
      end
      irfe_pkg::PROTO_NECX, irfe_pkg::PROTO_SAM: begin
        stream_next = {16'd0, command, address[15:0]};
        cnt_next    = 6'd32;
      end
      irfe_pkg::PROTO_RC5: begin
        stream_next = {34'd0, command[0], command[1], command[2], command[3],
                       command[4], command[5], address[0], address[1], address[2],
                       address[3], address[4], 1'b0, ~command[6], 1'b1};
        cnt_next    = 6'd14;
      end
      irfe_pkg::PROTO_SIRC: begin
        stream_next = {25'd0, address[15:0], command[6:0]};
        cnt_next    = 6'd7 + {1'b0, abits_sat};
      end
      irfe_pkg::PROTO_RC6: begin
        stream_next = {27'd0, irfe_pkg::rev8(command[7:0]), irfe_pkg::rev8(address[7:0]),
                       5'b00001};
        cnt_next    = 6'd21;
      end
      irfe_pkg::PROTO_KASE: begin
        stream_next = {kb5, kb4, kb3, kb2, kb1, kb0};
        cnt_next    = 6'd48;
      end
      default: ;
    endcase
  end

  assign biphase = (op == irfe_pkg::PROTO_RC5) || (op == irfe_pkg::PROTO_RC6);

  // Status to the controller
  assign sts.op_valid    = (op != irfe_pkg::PROTO_NONE);
  assign sts.has_header  = (op != irfe_pkg::PROTO_RC5);
  assign sts.has_trailer = (op != irfe_pkg::PROTO_RC5);
  assign sts.bit_done    = !biphase || half;
  assign sts.cnt_one     = (cnt == 6'd1);

  // Load the frame, then advance by half bit or whole bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      half <= 1'b0;
    end else if (cmd.load) begin
      op     <= operation;
      stream <= stream_next;
      cnt    <= cnt_next;
      half   <= 1'b0;
    end else if (cmd.advance) begin
      if (biphase && !half) begin
        half <= 1'b1;
      end else begin
        stream <= stream >> 1;
        cnt    <= cnt - 6'd1;
        half   <= 1'b0;
      end
    end
  end

  assign b = stream[0];

  // Pick the element durations and carrier
  always_comb begin
    mk  = '0;
    sp  = '0;
    car = irfe_pkg::CAR_36;
    case (irfe_pkg::proto_t'(op))
      irfe_pkg::PROTO_NEC, irfe_pkg::PROTO_NECX: begin
        car = irfe_pkg::CAR_38;
        case (cmd.sel)
          irfe_pkg::SEL_HEAD: begin mk = irfe_pkg::T_NEC_HM; sp = irfe_pkg::T_NEC_HS; end
          irfe_pkg::SEL_TAIL: begin mk = irfe_pkg::T_NEC_M;  sp = '0; end
          default: begin
            mk = irfe_pkg::T_NEC_M;
            sp = b ? irfe_pkg::T_NEC_S1 : irfe_pkg::T_NEC_M;
          end
        endcase
      end
      irfe_pkg::PROTO_RC5: begin
        car = irfe_pkg::CAR_36;
        mk  = (b == half) ? irfe_pkg::T_RC5_H : '0;
        sp  = (b == half) ? '0 : irfe_pkg::T_RC5_H;
      end
      irfe_pkg::PROTO_SAM: begin
        car = irfe_pkg::CAR_38;
        case (cmd.sel)
          irfe_pkg::SEL_HEAD: begin mk = irfe_pkg::T_SAM_H; sp = irfe_pkg::T_SAM_H; end
          irfe_pkg::SEL_TAIL: begin mk = irfe_pkg::T_SAM_M; sp = '0; end
          default: begin
            mk = irfe_pkg::T_SAM_M;
            sp = b ? irfe_pkg::T_SAM_S1 : irfe_pkg::T_SAM_M;
          end
        endcase
      end
      irfe_pkg::PROTO_SIRC: begin
        car = irfe_pkg::CAR_40;
        case (cmd.sel)
          irfe_pkg::SEL_HEAD: begin mk = irfe_pkg::T_SIRC_HM; sp = irfe_pkg::T_SIRC_U; end
          irfe_pkg::SEL_TAIL: begin mk = '0; sp = irfe_pkg::T_SIRC_GP; end
          default: begin
            mk = b ? irfe_pkg::T_SIRC_M1 : irfe_pkg::T_SIRC_U;
            sp = irfe_pkg::T_SIRC_U;
          end
        endcase
      end
      irfe_pkg::PROTO_RC6: begin
        car = irfe_pkg::CAR_36;
        case (cmd.sel)
          irfe_pkg::SEL_HEAD: begin mk = irfe_pkg::T_RC6_HM; sp = irfe_pkg::T_RC6_HS; end
          irfe_pkg::SEL_TAIL: begin mk = '0; sp = irfe_pkg::T_RC6_GP; end
          default: begin
            mk = (b != half) ? irfe_pkg::T_RC6_H : '0;
            sp = (b != half) ? '0 : irfe_pkg::T_RC6_H;
          end
        endcase
      end
      irfe_pkg::PROTO_KASE: begin
        car = irfe_pkg::CAR_38;
        case (cmd.sel)
          irfe_pkg::SEL_HEAD: begin mk = irfe_pkg::T_KASE_HM; sp = irfe_pkg::T_KASE_HS; end
          irfe_pkg::SEL_TAIL: begin mk = irfe_pkg::T_KASE_M;  sp = '0; end
          default: begin
            mk = irfe_pkg::T_KASE_M;
            sp = b ? irfe_pkg::T_KASE_S1 : irfe_pkg::T_KASE_M;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Register the element and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mark_time      <= mk;
      space_time     <= sp;
      carrier_select <= car;
      last           <= cmd.last;
    end
  end

endmodule

// ===== verif/ir_remote_frame_encoder_tb.sv =====
module ir_remote_frame_encoder_tb;
  import irfe_pkg::*;

  localparam logic [2:0] OP_UNUSED    = PROTO_NONE;
  localparam logic [6:0] LEN_ANY      = 7'h7F;
  localparam int         NUM_DIRECTED = 25;
  localparam int         NUM_RANDOM   = 445;
  localparam int         DRAIN_CYCLES = 64;

  // One mark/space element as it leaves the encoder
  typedef struct packed {
    logic [9:0] mark;
    logic [9:0] space;
    logic [1:0] car;
    logic       last;
  } elem_t;

  // Directed frame request, with frame length and header typed in where obvious
  typedef struct packed {
    logic [2:0]  op;
    logic [25:0] addr;
    logic [15:0] cmd;
    logic [4:0]  abits;
    logic [6:0]  exp_len;
    logic [9:0]  head_mark;
    logic [9:0]  head_space;
    logic [1:0]  head_car;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{PROTO_NEC,  26'h0000000, 16'h0000, 5'd0,  7'd34,   10'd900, 10'd450, CAR_38},
    '{PROTO_NEC,  26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd34,   10'd900, 10'd450, CAR_38},
    '{PROTO_NEC,  26'h00000A5, 16'h005A, 5'd3,  LEN_ANY, 10'd0,   10'd0,   CAR_36},
    '{PROTO_NECX, 26'h0000000, 16'h0000, 5'd0,  7'd34,   10'd900, 10'd450, CAR_38},
    '{PROTO_NECX, 26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd34,   10'd900, 10'd450, CAR_38},
    '{PROTO_NECX, 26'h000A55A, 16'hC33C, 5'd9,  LEN_ANY, 10'd0,   10'd0,   CAR_36},
    '{PROTO_RC5,  26'h0000000, 16'h0000, 5'd0,  7'd28,   10'd0,   10'd89,  CAR_36},
    '{PROTO_RC5,  26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd28,   10'd0,   10'd89,  CAR_36},
    '{PROTO_RC5,  26'h000001F, 16'h0040, 5'd1,  LEN_ANY, 10'd0,   10'd0,   CAR_36},
    '{PROTO_RC5,  26'h0000015, 16'h002A, 5'd2,  LEN_ANY, 10'd0,   10'd0,   CAR_36},
    '{PROTO_SAM,  26'h0000000, 16'h0000, 5'd0,  7'd34,   10'd450, 10'd450, CAR_38},
    '{PROTO_SAM,  26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd34,   10'd450, 10'd450, CAR_38},
    '{PROTO_SIRC, 26'h3FFFFFF, 16'hFFFF, 5'd0,  7'd9,    10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h0000015, 16'h0055, 5'd5,  7'd14,   10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h00000C3, 16'h002A, 5'd8,  7'd17,   10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h0001A5A, 16'h007F, 5'd13, 7'd22,   10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h3FFFFFF, 16'h0000, 5'd16, 7'd25,   10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h3FF5A5A, 16'hFF81, 5'd17, 7'd25,   10'd240, 10'd60,  CAR_40},
    '{PROTO_SIRC, 26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd25,   10'd240, 10'd60,  CAR_40},
    '{PROTO_RC6,  26'h0000000, 16'h0000, 5'd0,  7'd44,   10'd266, 10'd89,  CAR_36},
    '{PROTO_RC6,  26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd44,   10'd266, 10'd89,  CAR_36},
    '{PROTO_KASE, 26'h0000000, 16'h0000, 5'd0,  7'd50,   10'd338, 10'd169, CAR_38},
    '{PROTO_KASE, 26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd50,   10'd338, 10'd169, CAR_38},
    '{PROTO_KASE, 26'h1A5C3E7, 16'h03FF, 5'd7,  LEN_ANY, 10'd0,   10'd0,   CAR_36},
    '{OP_UNUSED,  26'h3FFFFFF, 16'hFFFF, 5'd31, 7'd0,    10'd0,   10'd0,   CAR_36}
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [25:0] address;
  logic [15:0] command;
  logic [4:0]  addr_width;
  logic [9:0]  mark_time;
  logic [9:0]  space_time;
  logic [1:0]  carrier_select;
  logic        last;
  logic        strobe;

  // Frame under construction and the elements still owed by the encoder
  logic [9:0]  frame_mark [64];
  logic [9:0]  frame_space [64];
  logic [1:0]  frame_car;
  int          frame_len;
  elem_t       pending_elems [$];
  int          fail_count;
  logic        no_idle;
  elem_t       exp_e;
  elem_t       got_e;

  ir_remote_frame_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .address        (address),
    .command        (command),
    .addr_width     (addr_width),
    .mark_time      (mark_time),
    .space_time     (space_time),
    .carrier_select (carrier_select),
    .last           (last),
    .strobe         (strobe)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Append one element to the frame being built
  function automatic void add_elem(input logic [9:0] m, input logic [9:0] s);
    frame_mark[frame_len]  = m;
    frame_space[frame_len] = s;
    frame_len++;
  endfunction

  // Pulse-distance bits, LSB first
  function automatic void add_pulse_dist(input logic [31:0] v, input int nbits,
                                         input logic [9:0] m, input logic [9:0] s1,
                                         input logic [9:0] s0);
    for (int i = 0; i < nbits; i++) add_elem(m, v[i] ? s1 : s0);
  endfunction

  // Manchester bit: a one goes out space half first
  function automatic void add_biphase(input logic b, input logic [9:0] h);
    if (b) begin
      add_elem(10'd0, h);
      add_elem(h, 10'd0);
    end else begin
      add_elem(h, 10'd0);
      add_elem(10'd0, h);
    end
  endfunction

  // Work out the whole element list of one frame request
  function automatic void build_frame(input logic [2:0] op, input logic [25:0] addr,
                                      input logic [15:0] cmd, input logic [4:0] abits);
    logic [7:0] by [6];
    logic [7:0] par;
    logic [7:0] inv_a;
    logic [7:0] inv_c;
    int         nsirc;
    frame_len = 0;
    frame_car = CAR_36;
    inv_a = ~addr[7:0];
    inv_c = ~cmd[7:0];
    case (op)
      PROTO_NEC: begin
        frame_car = CAR_38;
        add_elem(10'd900, 10'd450);
        add_pulse_dist({24'd0, addr[7:0]}, 8, 10'd56, 10'd168, 10'd56);
        add_pulse_dist({24'd0, inv_a}, 8, 10'd56, 10'd168, 10'd56);
        add_pulse_dist({24'd0, cmd[7:0]}, 8, 10'd56, 10'd168, 10'd56);
        add_pulse_dist({24'd0, inv_c}, 8, 10'd56, 10'd168, 10'd56);
        add_elem(10'd56, 10'd0);
      end
      PROTO_NECX: begin
        frame_car = CAR_38;
        add_elem(10'd900, 10'd450);
        add_pulse_dist({16'd0, addr[15:0]}, 16, 10'd56, 10'd168, 10'd56);
        add_pulse_dist({16'd0, cmd}, 16, 10'd56, 10'd168, 10'd56);
        add_elem(10'd56, 10'd0);
      end
      PROTO_RC5: begin
        // start, field (inverted command bit 6), toggle, then MSB first
        add_biphase(1'b1, 10'd89);
        add_biphase(~cmd[6], 10'd89);
        add_biphase(1'b0, 10'd89);
        for (int i = 4; i >= 0; i--) add_biphase(addr[i], 10'd89);
        for (int i = 5; i >= 0; i--) add_biphase(cmd[i], 10'd89);
      end
      PROTO_SAM: begin
        frame_car = CAR_38;
        add_elem(10'd450, 10'd450);
        add_pulse_dist({16'd0, addr[15:0]}, 16, 10'd55, 10'd165, 10'd55);
        add_pulse_dist({16'd0, cmd}, 16, 10'd55, 10'd165, 10'd55);
        add_elem(10'd55, 10'd0);
      end
      PROTO_SIRC: begin
        // clamp the address width at sixteen
        frame_car = CAR_40;
        nsirc = (abits > 5'd16) ? 16 : int'(abits);
        add_elem(10'd240, 10'd60);
        for (int i = 0; i < 7; i++) add_elem(cmd[i] ? 10'd120 : 10'd60, 10'd60);
        for (int i = 0; i < nsirc; i++) add_elem(addr[i] ? 10'd120 : 10'd60, 10'd60);
        add_elem(10'd0, 10'd1000);
      end
      PROTO_RC6: begin
        // a one goes out mark half first, so invert into the biphase helper
        add_elem(10'd266, 10'd89);
        add_biphase(1'b0, 10'd44);
        for (int i = 0; i < 4; i++) add_biphase(1'b1, 10'd44);
        for (int i = 7; i >= 0; i--) add_biphase(~addr[i], 10'd44);
        for (int i = 7; i >= 0; i--) add_biphase(~cmd[i], 10'd44);
        add_elem(10'd0, 10'd266);
      end
      PROTO_KASE: begin
        // pack vendor, nibble parity, genres, command and id, then byte parity
        frame_car = CAR_38;
        by[0] = addr[15:8];
        by[1] = addr[23:16];
        par   = by[0] ^ by[1];
        by[2] = {addr[7:4], par[3:0] ^ par[7:4]};
        by[3] = {cmd[3:0], addr[3:0]};
        by[4] = {addr[25:24], cmd[9:4]};
        by[5] = by[2] ^ by[3] ^ by[4];
        add_elem(10'd338, 10'd169);
        for (int k = 0; k < 6; k++)
          add_pulse_dist({24'd0, by[k]}, 8, 10'd42, 10'd126, 10'd42);
        add_elem(10'd42, 10'd0);
      end
      default: ;
    endcase
  endfunction

  // Hand the built frame over to the element checker
  function automatic void queue_frame();
    elem_t e;
    for (int i = 0; i < frame_len; i++) begin
      e.mark  = frame_mark[i];
      e.space = frame_space[i];
      e.car   = frame_car;
      e.last  = (i == frame_len - 1);
      pending_elems.push_back(e);
    end
  endfunction

  // Mostly short gaps, a few long ones, none during a back-to-back stretch
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Drop start and wiggle the fields while idle
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start      = 1'b0;
      operation  = 3'($urandom);
      address    = 26'($urandom);
      command    = 16'($urandom);
      addr_width = 5'($urandom);
    end
  endtask

  // Offer one item, hold it until taken, then predict its frame
  task automatic send_item(input logic [2:0] op, input logic [25:0] addr,
                           input logic [15:0] cmd, input logic [4:0] abits);
    @(negedge clk);
    start      = 1'b1;
    operation  = op;
    address    = addr;
    command    = cmd;
    addr_width = abits;
    @(posedge clk);
    while (busy) @(posedge clk);
    build_frame(op, addr, cmd, abits);
    queue_frame();
  endtask

  // Compare each strobed element with the oldest one owed
  always @(posedge clk) begin
    if (!rst && strobe) begin
      got_e = '{mark_time, space_time, carrier_select, last};
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected element mark %0d space %0d car %0d last %0b",
                 $time, mark_time, space_time, carrier_select, last);
        fail_count++;
      end else begin
        exp_e = pending_elems.pop_front();
        if (got_e.mark !== exp_e.mark) begin
          $display("%0t: mark_time expected %0d got %0d", $time, exp_e.mark, got_e.mark);
          fail_count++;
        end
        if (got_e.space !== exp_e.space) begin
          $display("%0t: space_time expected %0d got %0d", $time, exp_e.space, got_e.space);
          fail_count++;
        end
        if (got_e.car !== exp_e.car) begin
          $display("%0t: carrier_select expected %0d got %0d", $time, exp_e.car, got_e.car);
          fail_count++;
        end
        if (got_e.last !== exp_e.last) begin
          $display("%0t: last expected %0b got %0b", $time, exp_e.last, got_e.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    dir_row_t    row;
    int          sent;
    logic [2:0]  op;
    logic [25:0] addr;
    logic [15:0] cmd;
    logic [4:0]  abits;
    int          r;

    fail_count = 0;
    no_idle    = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    operation  = '0;
    address    = '0;
    command    = '0;
    addr_width = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table, checking typed frame lengths and headers
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      row = DIRECTED[n];
      idle_cycles(pick_gap());
      send_item(row.op, row.addr, row.cmd, row.abits);
      if (row.exp_len != LEN_ANY) begin
        if (frame_len != int'(row.exp_len)) begin
          $display("%0t: frame length expected %0d got %0d", $time, row.exp_len, frame_len);
          fail_count++;
        end else if (frame_len > 0 && (frame_mark[0] != row.head_mark ||
                     frame_space[0] != row.head_space || frame_car != row.head_car)) begin
          $display("%0t: first element expected %0d/%0d car %0d got %0d/%0d car %0d",
                   $time, row.head_mark, row.head_space, row.head_car,
                   frame_mark[0], frame_space[0], frame_car);
          fail_count++;
        end
      end
    end

    // Random frame requests, with occasional stretches of back-to-back items
    sent = 0;
    while (sent < NUM_RANDOM) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      r = $urandom_range(0, 15);
      op = (r == 15) ? OP_UNUSED : 3'(r % 7);
      r = $urandom_range(0, 9);
      addr = (r == 0) ? 26'h0 : (r == 1) ? 26'h3FFFFFF : 26'($urandom);
      r = $urandom_range(0, 9);
      cmd = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
      abits = $urandom_range(0, 1) ? 5'($urandom_range(0, 16)) : 5'($urandom);
      idle_cycles(pick_gap());
      send_item(op, addr, cmd, abits);
      sent++;
    end

    // Drain, then keep watching for stray elements
    idle_cycles(1);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/irfe_pkg.sv
rtl/core/irfe_ctrl.sv
rtl/core/irfe_datapath.sv
rtl/core/ir_remote_frame_encoder.sv
verif/ir_remote_frame_encoder_tb.sv
